// ===== rtl/core/lpfd_pkg.sv =====
// Shared types and constants of the length-prefixed frame deframer.
package lpfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 2 * ByteW;

  typedef enum logic [2:0] {
    PH_COUNTS  = 3'd0,
    PH_HEADER  = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_BODY    = 3'd3,
    PH_TERM    = 3'd4,
    PH_DONE    = 3'd5,
    PH_OVERRUN = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER_WORD = 2'd0,
    KIND_STRING_BYTE = 2'd1,
    KIND_STRING_END  = 2'd2,
    KIND_FRAME_END   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [WordW-1:0]   value;
    logic [WordW-1:0]   item_index;
    logic [WordW-1:0]   header_total;
    logic [WordW-1:0]   string_total;
    logic               frame_end;
    logic               frame_error;
  } result_t;

endpackage

// ===== rtl/core/lpfd_parser.sv =====
// Byte-wise frame parser: state registers and the per-byte next-state and result logic.
module lpfd_parser import lpfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             last_byte_i,
  output logic             produce_o,
  output result_t          result_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] high_latch_q, high_latch_d;
  logic [WordW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [WordW-1:0] str_cnt_q, str_cnt_d;
  logic [WordW-1:0] item_cnt_q, item_cnt_d;
  logic [WordW-1:0] cur_len_q, cur_len_d;
  logic [WordW-1:0] byte_cnt_q, byte_cnt_d;
  logic             complete_q, complete_d;

  logic [WordW-1:0] word;
  logic [WordW-1:0] item_inc;
  logic [WordW-1:0] byte_inc;
  logic             emit;
  kind_e            kind;
  logic [WordW-1:0] value;
  logic [WordW-1:0] index;

  assign word     = {high_latch_q, data_byte_i};
  assign item_inc = item_cnt_q + WordW'(1);
  assign byte_inc = byte_cnt_q + WordW'(1);

  always_comb begin
    phase_d      = phase_q;
    high_latch_d = high_latch_q;
    hdr_cnt_d    = hdr_cnt_q;
    str_cnt_d    = str_cnt_q;
    item_cnt_d   = item_cnt_q;
    cur_len_d    = cur_len_q;
    byte_cnt_d   = byte_cnt_q;
    complete_d   = complete_q;
    emit         = 1'b0;
    kind         = KIND_FRAME_END;
    value        = '0;
    index        = '0;

    case (phase_q)
      PH_COUNTS: begin
        if (byte_cnt_q == WordW'(0) || byte_cnt_q == WordW'(2)) begin
          high_latch_d = data_byte_i;
          byte_cnt_d   = byte_inc;
        end else if (byte_cnt_q == WordW'(1)) begin
          hdr_cnt_d  = word;
          byte_cnt_d = WordW'(2);
        end else begin
          str_cnt_d  = word;
          item_cnt_d = '0;
          byte_cnt_d = '0;
          if (hdr_cnt_q != '0) begin
            phase_d = PH_HEADER;
          end else if (word != '0) begin
            phase_d = PH_LENGTH;
          end else begin
            phase_d    = PH_DONE;
            complete_d = 1'b1;
          end
        end
      end
      PH_HEADER: begin
        if (byte_cnt_q == '0) begin
          high_latch_d = data_byte_i;
          byte_cnt_d   = WordW'(1);
        end else begin
          emit       = 1'b1;
          kind       = KIND_HEADER_WORD;
          value      = word;
          index      = item_cnt_q;
          byte_cnt_d = '0;
          item_cnt_d = item_inc;
          // Last header word: move on to the strings, or finish if there are none.
          if (item_inc == hdr_cnt_q) begin
            item_cnt_d = '0;
            if (str_cnt_q != '0) begin
              phase_d = PH_LENGTH;
            end else begin
              phase_d    = PH_DONE;
              complete_d = 1'b1;
            end
          end
        end
      end
      PH_LENGTH: begin
        if (byte_cnt_q == '0) begin
          high_latch_d = data_byte_i;
          byte_cnt_d   = WordW'(1);
        end else begin
          cur_len_d  = word;
          byte_cnt_d = '0;
          phase_d    = (word != '0) ? PH_BODY : PH_TERM;
        end
      end
      PH_BODY: begin
        emit       = 1'b1;
        kind       = KIND_STRING_BYTE;
        value      = {{ByteW{1'b0}}, data_byte_i};
        index      = item_cnt_q;
        byte_cnt_d = byte_inc;
        if (byte_inc == cur_len_q) begin
          phase_d = PH_TERM;
        end
      end
      PH_TERM: begin
        emit       = 1'b1;
        kind       = KIND_STRING_END;
        value      = cur_len_q;
        index      = item_cnt_q;
        byte_cnt_d = '0;
        item_cnt_d = item_inc;
        if (item_inc == str_cnt_q) begin
          phase_d    = PH_DONE;
          complete_d = 1'b1;
        end else begin
          phase_d = PH_LENGTH;
        end
      end
      default: begin
        phase_d = PH_OVERRUN;
      end
    endcase
  end

  assign produce_o = emit || last_byte_i;

  always_comb begin
    result_o.kind         = kind;
    result_o.value        = value;
    result_o.item_index   = index;
    result_o.header_total = hdr_cnt_d;
    result_o.string_total = str_cnt_d;
    result_o.frame_end    = last_byte_i;
    result_o.frame_error  = last_byte_i && !(phase_d == PH_DONE && complete_d);
  end

  // Return to the reset state after the frame's final byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_COUNTS;
      high_latch_q <= '0;
      hdr_cnt_q    <= '0;
      str_cnt_q    <= '0;
      item_cnt_q   <= '0;
      cur_len_q    <= '0;
      byte_cnt_q   <= '0;
      complete_q   <= 1'b0;
    end else if (adv_i) begin
      if (last_byte_i) begin
        phase_q      <= PH_COUNTS;
        high_latch_q <= '0;
        hdr_cnt_q    <= '0;
        str_cnt_q    <= '0;
        item_cnt_q   <= '0;
        cur_len_q    <= '0;
        byte_cnt_q   <= '0;
        complete_q   <= 1'b0;
      end else begin
        phase_q      <= phase_d;
        high_latch_q <= high_latch_d;
        hdr_cnt_q    <= hdr_cnt_d;
        str_cnt_q    <= str_cnt_d;
        item_cnt_q   <= item_cnt_d;
        cur_len_q    <= cur_len_d;
        byte_cnt_q   <= byte_cnt_d;
        complete_q   <= complete_d;
      end
    end
  end

endmodule

// ===== rtl/core/lpfd_out_reg.sv =====
// Result register that holds one item until the downstream side takes it.
module lpfd_out_reg import lpfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output logic    busy_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // The slot is busy while a held item is still stalled.
  assign busy_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

// ===== rtl/core/length_prefixed_frame_deframer_unit.sv =====
// Top level of the length-prefixed frame deframer: input register, parser and result register.
//
// Takes one frame byte per cycle while the input is not stalled and emits header words, string
// bytes and string-end items, plus a frame-end report on the byte marked last. Throughput is
// one byte per cycle while nothing stalls; an accepted byte is held in the input register and
// goes through the parser into the result register. The rate is set by the parser's single
// byte-wise state update, which runs once per cycle between the input register and the result
// register. Bytes that produce no result pass through even while the result slot is stalled;
// a byte that produces a result waits in the input register until the result slot frees up.
module length_prefixed_frame_deframer_unit import lpfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic [WordW-1:0] value_o,
  output logic [WordW-1:0] item_index_o,
  output logic [WordW-1:0] header_total_o,
  output logic [WordW-1:0] string_total_o,
  output logic             frame_end_o,
  output logic             frame_error_o
);

  logic             s1_valid_q, s1_valid_d;
  logic [ByteW-1:0] s1_data_q;
  logic             s1_last_q;
  logic             s1_adv;
  logic             produce;
  logic             out_busy;
  result_t          parse_res;
  result_t          out_res;

  // Advance the held byte unless it needs the result slot and the slot is stalled.
  assign s1_adv     = s1_valid_q && !(produce && out_busy);
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  lpfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .data_byte_i (s1_data_q),
    .last_byte_i (s1_last_q),
    .produce_o   (produce),
    .result_o    (parse_res)
  );

  lpfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv && produce),
    .result_i    (parse_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .busy_o      (out_busy),
    .result_o    (out_res)
  );

  assign kind_o         = out_res.kind;
  assign value_o        = out_res.value;
  assign item_index_o   = out_res.item_index;
  assign header_total_o = out_res.header_total;
  assign string_total_o = out_res.string_total;
  assign frame_end_o    = out_res.frame_end;
  assign frame_error_o  = out_res.frame_error;

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with no byte held");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && produce) |=> out_valid_o)
    else $error("produced item did not reach the result register");

  a_frame_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_FRAME_END) |-> frame_end_o)
    else $error("frame-end-only item without frame_end");

  a_error_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_error_o) |-> frame_end_o)
    else $error("frame_error outside the final item");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the length-prefixed frame deframer unit.
module tb_top;
  import lpfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomItems = 1150;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned MaxShown = 10;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [ByteW-1:0] data_byte_i;
  logic             last_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [1:0]       kind_o;
  logic [WordW-1:0] value_o;
  logic [WordW-1:0] item_index_o;
  logic [WordW-1:0] header_total_o;
  logic [WordW-1:0] string_total_o;
  logic             frame_end_o;
  logic             frame_error_o;

  length_prefixed_frame_deframer_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .value_o        (value_o),
    .item_index_o   (item_index_o),
    .header_total_o (header_total_o),
    .string_total_o (string_total_o),
    .frame_end_o    (frame_end_o),
    .frame_error_o  (frame_error_o)
  );

  // Parser state mirrored by the testbench
  phase_e           parse_phase;
  logic [ByteW-1:0] hi_byte;
  logic [WordW-1:0] hdr_words;
  logic [WordW-1:0] str_count;
  logic [WordW-1:0] seq_idx;
  logic [WordW-1:0] str_len;
  logic [WordW-1:0] byte_pos;
  logic             struct_done;

  result_t          pending_results[$];
  logic [ByteW-1:0] frame_buf[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned counted_items = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  int          hold_req = 0;
  int          hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver: long hold-off on request, otherwise random stalls when enabled
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = HoldCycles;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= sink_idle_on && ($urandom_range(99) < 8);
      end
    end
  end

  function automatic void clear_parser();
    parse_phase = PH_COUNTS;
    hi_byte     = '0;
    hdr_words   = '0;
    str_count   = '0;
    seq_idx     = '0;
    str_len     = '0;
    byte_pos    = '0;
    struct_done = 1'b0;
  endfunction

  function automatic void start_strings();
    seq_idx  = '0;
    byte_pos = '0;
    if (str_count != 0) begin
      parse_phase = PH_LENGTH;
    end else begin
      parse_phase = PH_DONE;
      struct_done = 1'b1;
    end
  endfunction

  // Advance the mirrored parser by one byte and queue any result it causes
  function automatic void deframe_byte(input logic [ByteW-1:0] b, input logic fin);
    result_t          r;
    logic             emit;
    logic [WordW-1:0] w;
    r      = '0;
    r.kind = KIND_FRAME_END;
    emit   = 1'b0;
    w      = {hi_byte, b};
    case (parse_phase)
      PH_COUNTS: begin
        if (byte_pos == 0 || byte_pos == 2) begin
          hi_byte = b;
          byte_pos++;
        end else if (byte_pos == 1) begin
          hdr_words = w;
          byte_pos  = 2;
        end else begin
          str_count = w;
          seq_idx   = '0;
          byte_pos  = '0;
          if (hdr_words != 0) parse_phase = PH_HEADER;
          else start_strings();
        end
      end
      PH_HEADER: begin
        if (byte_pos == 0) begin
          hi_byte  = b;
          byte_pos = 1;
        end else begin
          emit         = 1'b1;
          r.kind       = KIND_HEADER_WORD;
          r.value      = w;
          r.item_index = seq_idx;
          byte_pos     = 0;
          seq_idx++;
          if (seq_idx == hdr_words) start_strings();
        end
      end
      PH_LENGTH: begin
        if (byte_pos == 0) begin
          hi_byte  = b;
          byte_pos = 1;
        end else begin
          str_len     = w;
          byte_pos    = 0;
          parse_phase = (w != 0) ? PH_BODY : PH_TERM;
        end
      end
      PH_BODY: begin
        emit         = 1'b1;
        r.kind       = KIND_STRING_BYTE;
        r.value      = {8'h00, b};
        r.item_index = seq_idx;
        byte_pos++;
        if (byte_pos == str_len) parse_phase = PH_TERM;
      end
      PH_TERM: begin
        emit         = 1'b1;
        r.kind       = KIND_STRING_END;
        r.value      = str_len;
        r.item_index = seq_idx;
        byte_pos     = 0;
        seq_idx++;
        if (seq_idx == str_count) begin
          parse_phase = PH_DONE;
          struct_done = 1'b1;
        end else begin
          parse_phase = PH_LENGTH;
        end
      end
      default: parse_phase = PH_OVERRUN;
    endcase
    if (emit || fin) begin
      r.header_total = hdr_words;
      r.string_total = str_count;
      if (fin) begin
        r.frame_end   = 1'b1;
        r.frame_error = !(parse_phase == PH_DONE && struct_done);
        clear_parser();
      end
      pending_results.push_back(r);
    end
  endfunction

  function automatic void note_field(input string name, input int unsigned want,
                                     input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MaxShown)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxShown)
          $display("unexpected result: kind %0d value %h index %h",
                   kind_o, value_o, item_index_o);
      end else begin
        want = pending_results.pop_front();
        note_field("kind", want.kind, kind_o);
        note_field("value", want.value, value_o);
        note_field("item_index", want.item_index, item_index_o);
        note_field("header_total", want.header_total, header_total_o);
        note_field("string_total", want.string_total, string_total_o);
        note_field("frame_end", want.frame_end, frame_end_o);
        note_field("frame_error", want.frame_error, frame_error_o);
      end
    end
  end

  // Enter and leave at a falling edge; valid stays high between items unless a random idle gap is inserted
  task automatic send_byte(input logic [ByteW-1:0] b, input logic fin);
    int gap;
    if (src_idle_on && $urandom_range(99) < 8) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    if (parse_phase != PH_DONE && parse_phase != PH_OVERRUN) counted_items++;
    deframe_byte(b, fin);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // Well-formed frame with random content
  task automatic build_frame(input logic [WordW-1:0] nh, input logic [WordW-1:0] ns,
                             input int maxlen);
    int len;
    frame_buf = {};
    frame_buf.push_back(nh[15:8]);
    frame_buf.push_back(nh[7:0]);
    frame_buf.push_back(ns[15:8]);
    frame_buf.push_back(ns[7:0]);
    repeat (2 * nh) frame_buf.push_back(ByteW'($urandom_range(0, 255)));
    repeat (ns) begin
      len = $urandom_range(0, maxlen);
      frame_buf.push_back(ByteW'(len >> 8));
      frame_buf.push_back(ByteW'(len));
      repeat (len) frame_buf.push_back(ByteW'($urandom_range(0, 255)));
      frame_buf.push_back(ByteW'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_empty_frame();
    frame_buf = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_frame();
  endtask

  task automatic test_last_on_first_byte();
    frame_buf = '{8'hff};
    send_frame();
  endtask

  // One header word, a zero-length string and a one-byte string ending on its terminator
  task automatic test_full_structure();
    frame_buf = '{8'h00, 8'h01, 8'h00, 8'h02, 8'hff, 8'hff,
                  8'h00, 8'h00, 8'haa, 8'h00, 8'h01, 8'h00, 8'h55};
    send_frame();
  endtask

  task automatic test_missing_terminator();
    frame_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
    send_frame();
  endtask

  task automatic test_extra_bytes();
    frame_buf = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h7f};
    send_frame();
  endtask

  task automatic test_random_frames();
    int roll;
    int cut;
    while (counted_items < RandomItems) begin
      src_idle_on  = !(counted_items >= 400 && counted_items < 700);
      sink_idle_on = src_idle_on;
      roll = $urandom_range(99);
      if (roll < 10) begin
        frame_buf = {};
        repeat ($urandom_range(1, 12)) frame_buf.push_back(ByteW'($urandom_range(0, 255)));
      end else begin
        build_frame(WordW'($urandom_range(0, 3)), WordW'($urandom_range(0, 3)), 6);
        if (roll < 20) begin
          // drop a random tail, possibly empty, so the frame can end early
          cut = $urandom_range(1, frame_buf.size());
          frame_buf = frame_buf[0:cut-1];
        end else if (roll < 28) begin
          repeat ($urandom_range(1, 3)) frame_buf.push_back(ByteW'($urandom_range(0, 255)));
        end
      end
      send_frame();
      if ($urandom_range(14) == 0) wait_drained();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering string bytes
  task automatic test_output_hold_off();
    src_idle_on = 1'b0;
    hold_req    = 1;
    frame_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'd40};
    repeat (40) frame_buf.push_back(ByteW'($urandom_range(0, 255)));
    frame_buf.push_back(8'h00);
    send_frame();
    src_idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    build_frame(16'd2, 16'd2, 4);
    send_frame();
    wait_drained();
    build_frame(16'd1, 16'd1, 3);
    send_frame();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    clear_parser();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_frame();
    test_last_on_first_byte();
    test_full_structure();
    test_missing_terminator();
    test_extra_bytes();
    test_random_frames();
    test_output_hold_off();
    test_sender_pause();

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lpfd_pkg.sv
rtl/core/lpfd_parser.sv
rtl/core/lpfd_out_reg.sv
rtl/core/length_prefixed_frame_deframer_unit.sv
test/tb_top.sv
